/* hw/rtl/chat_packet_field_parser_macros.svh */
// Assertion helpers used by the RTL.
`ifndef CHAT_PACKET_FIELD_PARSER_MACROS_SVH
`define CHAT_PACKET_FIELD_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define CPFP_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define CPFP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define CPFP_ASSERT_SAME(label, clk, rst, pre, post)
`define CPFP_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

/* hw/rtl/cpfp_pkg.sv */
package cpfp_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned LenWidth  = 16;
   localparam logic [7:0]  BroadcastFlagReset = 8'd4;
   localparam logic [15:0] LenBytes = 16'd2;

   typedef enum logic [3:0] {
      ROLE_LEN_HI   = 4'd0,
      ROLE_LEN_LO   = 4'd1,
      ROLE_FLAG     = 4'd2,
      ROLE_SND_LEN  = 4'd3,
      ROLE_SND_CHR  = 4'd4,
      ROLE_DST_CNT  = 4'd5,
      ROLE_DST_LEN  = 4'd6,
      ROLE_DST_CHR  = 4'd7,
      ROLE_MESSAGE  = 4'd8
   } role_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_SHORT = 2'd1,
      ERR_TRUNC = 2'd2
   } error_type;

   typedef struct packed {
      role_type             field_role;
      logic [ByteWidth-1:0] data_byte;
      logic [7:0]           handle_index;
      logic                 field_end;
      logic                 packet_end;
      error_type            parse_error;
   } result_type;

endpackage

/* hw/rtl/cpfp_parser.sv */
module cpfp_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          stream_byte,
   input  logic [7:0]          broadcast_flag,
   output cpfp_pkg::result_type result
);
   import cpfp_pkg::*;

   typedef enum logic [3:0] {
      ST_LEN_HI  = 4'd0,
      ST_LEN_LO  = 4'd1,
      ST_FLAG    = 4'd2,
      ST_SND_LEN = 4'd3,
      ST_SND_CHR = 4'd4,
      ST_DST_CNT = 4'd5,
      ST_DST_LEN = 4'd6,
      ST_DST_CHR = 4'd7,
      ST_MESSAGE = 4'd8
   } state_type;

   state_type            state_ff, state_in, next_st;
   logic [LenWidth-1:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]           length_high_ff, length_high_in;
   logic [7:0]           field_left_ff, field_left_in;
   logic [7:0]           dests_left_ff, dests_left_in;
   logic [7:0]           handle_ff, handle_in;
   logic                 broadcast_ff, broadcast_in;

   logic [LenWidth-1:0]  total;
   logic [LenWidth-1:0]  bytes_dec;
   logic [7:0]           field_dec;
   logic [7:0]           dests_dec;
   logic [7:0]           handle_inc;
   state_type            after_sender;
   state_type            after_dest;
   logic                 counted;

   assign total        = {length_high_ff, stream_byte};
   assign bytes_dec    = bytes_left_ff - 16'd1;
   assign field_dec    = field_left_ff - 8'd1;
   assign dests_dec    = dests_left_ff - 8'd1;
   assign handle_inc   = handle_ff + 8'd1;
   assign after_sender = broadcast_ff ? ST_MESSAGE : ST_DST_CNT;
   assign after_dest   = (dests_dec != 8'd0) ? ST_DST_LEN : ST_MESSAGE;

   always_comb begin
      next_st        = ST_LEN_HI;
      bytes_left_in  = bytes_left_ff;
      length_high_in = length_high_ff;
      field_left_in  = field_left_ff;
      dests_left_in  = dests_left_ff;
      handle_in      = handle_ff;
      broadcast_in   = broadcast_ff;
      counted        = 1'b1;
      result.field_role   = ROLE_LEN_HI;
      result.data_byte    = stream_byte;
      result.handle_index = 8'd0;
      result.field_end    = 1'b0;
      result.packet_end   = 1'b0;
      result.parse_error  = ERR_NONE;

      unique case (state_ff)
         ST_LEN_LO: begin
            result.field_role = ROLE_LEN_LO;
            result.field_end  = 1'b1;
            counted           = 1'b0;
            if (total < LenBytes + 16'd1) begin
               result.parse_error = ERR_SHORT;
               result.packet_end  = 1'b1;
               next_st            = ST_LEN_HI;
            end else begin
               bytes_left_in = total - LenBytes;
               next_st       = ST_FLAG;
            end
         end
         ST_FLAG: begin
            result.field_role = ROLE_FLAG;
            result.field_end  = 1'b1;
            broadcast_in      = (stream_byte == broadcast_flag);
            next_st           = ST_SND_LEN;
         end
         ST_SND_LEN: begin
            result.field_role = ROLE_SND_LEN;
            result.field_end  = 1'b1;
            field_left_in     = stream_byte;
            handle_in         = 8'd0;
            next_st           = (stream_byte != 8'd0) ? ST_SND_CHR : after_sender;
         end
         ST_SND_CHR: begin
            result.field_role = ROLE_SND_CHR;
            field_left_in     = field_dec;
            if (field_dec == 8'd0) begin
               result.field_end = 1'b1;
               next_st          = after_sender;
            end else begin
               next_st = ST_SND_CHR;
            end
         end
         ST_DST_CNT: begin
            result.field_role = ROLE_DST_CNT;
            result.field_end  = 1'b1;
            dests_left_in     = stream_byte;
            handle_in         = 8'd0;
            next_st           = (stream_byte != 8'd0) ? ST_DST_LEN : ST_MESSAGE;
         end
         ST_DST_LEN: begin
            result.field_role   = ROLE_DST_LEN;
            result.field_end    = 1'b1;
            result.handle_index = handle_inc;
            handle_in           = handle_inc;
            field_left_in       = stream_byte;
            if (stream_byte != 8'd0) begin
               next_st = ST_DST_CHR;
            end else begin
               dests_left_in = dests_dec;
               next_st       = after_dest;
            end
         end
         ST_DST_CHR: begin
            result.field_role   = ROLE_DST_CHR;
            result.handle_index = handle_ff;
            field_left_in       = field_dec;
            if (field_dec == 8'd0) begin
               result.field_end = 1'b1;
               dests_left_in    = dests_dec;
               next_st          = after_dest;
            end else begin
               next_st = ST_DST_CHR;
            end
         end
         ST_MESSAGE: begin
            result.field_role = ROLE_MESSAGE;
            next_st           = ST_MESSAGE;
         end
         default: begin
            // length high byte, also recovers from unused codes
            result.field_role = ROLE_LEN_HI;
            length_high_in    = stream_byte;
            counted           = 1'b0;
            next_st           = ST_LEN_LO;
         end
      endcase

      state_in = next_st;
      if (counted) begin
         bytes_left_in = bytes_dec;
         if (bytes_dec == 16'd0) begin
            result.packet_end = 1'b1;
            result.field_end  = 1'b1;
            if (next_st != ST_MESSAGE) begin
               result.parse_error = ERR_TRUNC;
            end
            state_in = ST_LEN_HI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LEN_HI;
         bytes_left_ff  <= '0;
         length_high_ff <= '0;
         field_left_ff  <= '0;
         dests_left_ff  <= '0;
         handle_ff      <= '0;
         broadcast_ff   <= 1'b0;
      end else if (step) begin
         state_ff       <= state_in;
         bytes_left_ff  <= bytes_left_in;
         length_high_ff <= length_high_in;
         field_left_ff  <= field_left_in;
         dests_left_ff  <= dests_left_in;
         handle_ff      <= handle_in;
         broadcast_ff   <= broadcast_in;
      end
   end

endmodule

/* hw/rtl/chat_packet_field_parser.sv */
// Channel   Dir  Handshake           Word
// req_      in   req_valid/ready     one stream byte
// rsp_      out  rsp_valid/ready     tagged byte: role, data, handle, ends, error
// csr_      in   csr_write_en        broadcast flag value
//
// One word in, one word out, one word per cycle sustained while rsp_ready stays high.
// Each accepted result is registered into the output register, or into the skid
// entry while the output stalls; the parser state advances on the accepting edge.
// A two-entry output (register plus skid) keeps req_ready registered;
// req_ready drops only while both entries hold words.
// Synchronous reset clears parser state, valids and the flag (to 4).
`include "chat_packet_field_parser_macros.svh"

module chat_packet_field_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_stream_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cpfp_pkg::role_type   rsp_field_role,
   output logic [7:0]           rsp_data_byte,
   output logic [7:0]           rsp_handle_index,
   output logic                 rsp_field_end,
   output logic                 rsp_packet_end,
   output cpfp_pkg::error_type  rsp_parse_error,
   input  logic                 csr_write_en,
   input  logic [7:0]           csr_write_data
);
   import cpfp_pkg::*;

   logic [7:0]  bcast_ff;
   result_type  result;
   result_type  out_ff;
   result_type  skid_ff;
   logic        out_valid_ff;
   logic        skid_valid_ff;
   logic        accept;
   logic        out_take;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_take  = !out_valid_ff || rsp_ready;

   cpfp_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (accept),
      .stream_byte    (req_stream_byte),
      .broadcast_flag (bcast_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bcast_ff <= BroadcastFlagReset;
      end else if (csr_write_en) begin
         bcast_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            if (accept) begin
               out_ff <= result;
            end
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_ff       <= result;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_field_role   = out_ff.field_role;
   assign rsp_data_byte    = out_ff.data_byte;
   assign rsp_handle_index = out_ff.handle_index;
   assign rsp_field_end    = out_ff.field_end;
   assign rsp_packet_end   = out_ff.packet_end;
   assign rsp_parse_error  = out_ff.parse_error;

   `CPFP_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `CPFP_ASSERT_NEXT(a_stall_fills_skid, clock, reset, accept && !out_take, skid_valid_ff)
   `CPFP_ASSERT_SAME(a_pend_has_fend, clock, reset, rsp_valid && rsp_packet_end, rsp_field_end)
   `CPFP_ASSERT_SAME(a_err_ends_packet, clock, reset, rsp_valid && rsp_parse_error != ERR_NONE, rsp_packet_end)
   `CPFP_ASSERT_NEXT(a_csr_lands, clock, reset, csr_write_en, bcast_ff == $past(csr_write_data))

endmodule
